>>> hw/rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg: shared types and codes for the positional list store
// Field widths, request kinds, status codes and the word structs.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int KIND_W = 2;
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data_out;
    logic [CNT_W-1:0]         count_out;
  } rsp_t;

endpackage

>>> hw/rtl/pls_if.sv
// ----------------------------------------------------------------------------
// pls_if: request and response channels of the positional list store
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pls_req_if;
  import pls_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

interface pls_rsp_if;
  import pls_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] data_out;
  logic [CNT_W-1:0]         count_out;

  modport source (output valid, output status, output data_out, output count_out, input ready);
  modport sink   (input valid, input status, input data_out, input count_out, output ready);
endinterface

>>> hw/rtl/pls_core.sv
// ----------------------------------------------------------------------------
// pls_core: list storage and combinational request evaluation
// Holds the entry registers and the count; computes the response word and
// shifts all entries in parallel on insert or delete when enabled.
// ----------------------------------------------------------------------------
module pls_core #(
  parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  pls_pkg::req_t req,
  output pls_pkg::rsp_t rsp
);
  import pls_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic signed [DATA_W-1:0] entries [DEPTH];
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;

  logic [POS_W:0]   pos_ext;
  logic [POS_W:0]   cnt_ext;
  logic [POS_W-1:0] pos_m1;
  logic [IDX_W-1:0] rd_idx;
  logic             ins_range;
  logic             acc_range;
  logic             is_full;
  logic             do_ins;
  logic             do_del;
  logic signed [DATA_W-1:0] rd_data;

  assign pos_ext   = {1'b0, req.position};
  assign cnt_ext   = (POS_W + 1)'(count);
  assign pos_m1    = req.position - POS_W'(1);
  assign rd_idx    = pos_m1[IDX_W-1:0];
  assign ins_range = (req.position != '0) && (pos_ext <= cnt_ext + (POS_W + 1)'(1));
  assign acc_range = (req.position != '0) && (pos_ext <= cnt_ext);
  assign is_full   = (count >= DEPTH_C);
  assign rd_data   = acc_range ? entries[rd_idx] : '0;

  always_comb begin
    rsp        = '0;
    rsp.status = ST_RANGE;
    do_ins     = 1'b0;
    do_del     = 1'b0;
    count_next = count;
    unique case (req.kind)
      KIND_INSERT: begin
        if (ins_range) begin
          if (is_full) begin
            rsp.status = ST_FULL;
          end else begin
            rsp.status = ST_OK;
            do_ins     = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
      end
      KIND_DELETE: begin
        if (acc_range) begin
          rsp.status   = ST_OK;
          rsp.data_out = rd_data;
          do_del       = 1'b1;
          count_next   = count - CNT_W'(1);
        end
      end
      KIND_READ: begin
        if (acc_range) begin
          rsp.status   = ST_OK;
          rsp.data_out = rd_data;
        end
      end
      default: begin
      end
    endcase
    rsp.count_out = count_next;
  end

  // slot i takes the new value, its lower neighbor (insert) or upper neighbor (delete)
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    localparam logic [POS_W-1:0] IDX = POS_W'(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (do_ins) begin
          if (IDX == pos_m1) begin
            entries[i] <= req.value;
          end else if (IDX > pos_m1) begin
            entries[i] <= entries[(i == 0) ? 0 : i - 1];
          end
        end else if (do_del) begin
          if (IDX >= pos_m1) begin
            entries[i] <= entries[(i == DEPTH - 1) ? i : i + 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (en) begin
      count <= count_next;
    end
  end

endmodule

>>> hw/rtl/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store: bounded ordered list with insert/delete/read by position
//
// Channels: req (sink) carries kind, position and value; rsp (source) carries
// status, data_out and count_out. A word moves when valid and ready are high.
// Every request word yields exactly one response word, in order.
// Positions are 1-based. Insert accepts 1..count+1, delete and read 1..count.
// Out-of-range requests report status range; insert into a full list reports
// full. Neither changes the list.
// Latency: the response is valid in the cycle after the request is taken.
// Throughput: one request per cycle while rsp takes each response; the whole
// list shifts in parallel, and the response register sits between the channels.
// Stall: while rsp is valid and not taken, req.ready is low and the list holds.
// Reset: count clears to zero and the response register empties; entry
// contents are not cleared, since only slots below count are ever read.
// ----------------------------------------------------------------------------
module positional_list_store #(
  parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  pls_req_if.sink   req,
  pls_rsp_if.source rsp
);
  import pls_pkg::*;

  req_t req_word;
  rsp_t rsp_word;
  rsp_t rsp_reg;
  logic rsp_valid;
  logic take;

  assign req.ready = !rsp_valid || rsp.ready;
  assign take      = req.valid && req.ready;

  assign req_word.kind     = req.kind;
  assign req_word.position = req.position;
  assign req_word.value    = req.value;

  pls_core #(.DEPTH(DEPTH)) u_core (
    .clk (clk),
    .rst (rst),
    .en  (take),
    .req (req_word),
    .rsp (rsp_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp_reg <= rsp_word;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_reg.status;
  assign rsp.data_out  = rsp_reg.data_out;
  assign rsp.count_out = rsp_reg.count_out;

`ifndef SYNTHESIS
  a_resp_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> rsp_valid)
    else $error("accepted request produced no response");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_reg.count_out <= CNT_W'(DEPTH)))
    else $error("count exceeds depth");

  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_reg.status != ST_OK) |-> (rsp_reg.data_out == '0))
    else $error("nonzero data on failed request");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_reg.status == ST_FULL) |-> (rsp_reg.count_out == CNT_W'(DEPTH)))
    else $error("full status with list not full");
`endif

endmodule
